>>> hw/rtl/box_blur_running_average_macros.svh
// Assertion macros shared by the box blur checker.
`ifndef BOX_BLUR_RUNNING_AVERAGE_MACROS_SVH
`define BOX_BLUR_RUNNING_AVERAGE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define BBRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BBRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bbra_pkg.sv
// Types and constants of the box blur running average block.
package bbra_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned DIV_STEPS = 33;

  localparam logic [15:0] WIN_RESET   = 16'd3;
  localparam logic [31:0] RECIP_RESET = 32'((64'd1 << 32) / 64'(WIN_RESET));
  localparam logic [15:0] HALF_RESET  = WIN_RESET >> 1;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] add_lane0;
    logic [31:0] add_lane1;
    logic [31:0] add_lane2;
    logic [31:0] add_lane3;
    logic [31:0] sub_lane0;
    logic [31:0] sub_lane1;
    logic [31:0] sub_lane2;
    logic [31:0] sub_lane3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [31:0] sum_out0;
    logic [31:0] sum_out1;
    logic [31:0] sum_out2;
    logic [31:0] sum_out3;
  } out_item_t;

  // Queued operation: load value or net delta per lane.
  typedef struct packed {
    kind_e                   kind;
    logic [LANES-1:0][31:0] val;
  } op_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] recip;
    logic [15:0] half;
  } recip_stat_t;

endpackage

>>> hw/rtl/bbra_recip.sv
// Window register and bit-serial reciprocal unit: floor(2^32 / window).
module bbra_recip (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  output bbra_pkg::recip_stat_t stat_o
);
  import bbra_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic [15:0]      win_q;
  logic [15:0]      half_q;
  logic [31:0]      recip_q, recip_d;
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [16:0]      rem_q, rem_d;
  logic [31:0]      quo_q, quo_d;
  logic [16:0]      rem_sh;
  logic             ge;
  logic             last;

  // Dividend is a single one at bit 32 followed by zeros.
  always_comb begin
    rem_sh  = {rem_q[15:0], (cnt_q == '0)};
    ge      = (rem_sh >= {1'b0, win_q});
    rem_d   = ge ? (rem_sh - {1'b0, win_q}) : rem_sh;
    quo_d   = {quo_q[30:0], ge};
    last    = (cnt_q == CNT_W'(DIV_STEPS - 1));
    cnt_d   = cnt_q + 1'b1;
    busy_d  = busy_q && !last;
    recip_d = (win_q == '0) ? '0 : quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= WIN_RESET;
      half_q  <= HALF_RESET;
      recip_q <= RECIP_RESET;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      win_q  <= cfg_wdata_i;
      half_q <= cfg_wdata_i >> 1;
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (last) begin
        recip_q <= recip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o = '{busy: busy_q, recip: recip_q, half: half_q};

endmodule

>>> hw/rtl/bbra_front.sv
// Front end: accepts input items, classifies them and folds add/sub per lane.
module bbra_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bbra_pkg::in_item_t   in_data_i,
  input  logic                 q_full_i,
  input  bbra_pkg::recip_stat_t stat_i,
  output logic                 push_o,
  output bbra_pkg::op_t        op_o
);
  import bbra_pkg::*;

  logic [LANES-1:0][31:0] add_v;
  logic [LANES-1:0][31:0] sub_v;

  assign add_v = {in_data_i.add_lane3, in_data_i.add_lane2,
                  in_data_i.add_lane1, in_data_i.add_lane0};
  assign sub_v = {in_data_i.sub_lane3, in_data_i.sub_lane2,
                  in_data_i.sub_lane1, in_data_i.sub_lane0};

  // Hold off items while the reciprocal is being recomputed.
  assign in_ready_o = !q_full_i && !stat_i.busy;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    op_o.kind = kind_e'(in_data_i.kind);
    for (int j = 0; j < LANES; j++) begin
      case (op_o.kind)
        KIND_LOAD: op_o.val[j] = add_v[j];
        KIND_STEP: op_o.val[j] = add_v[j] - sub_v[j];
        default:   op_o.val[j] = add_v[j];
      endcase
    end
  end

endmodule

>>> hw/rtl/bbra_fifo.sv
// Small queue between front and back end.
module bbra_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bbra_pkg::op_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bbra_pkg::op_t pop_data_o
);
  import bbra_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/bbra_back.sv
// Back end: running sums, reciprocal multiply and pixel assembly.
module bbra_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  input  bbra_pkg::op_t         op_i,
  output logic                  op_pop_o,
  input  bbra_pkg::recip_stat_t stat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bbra_pkg::out_item_t   out_data_o
);
  import bbra_pkg::*;

  logic                   adv;
  logic                   take;

  logic [LANES-1:0][31:0] sums_q, sums_d;
  logic [LANES-1:0][31:0] t_d;

  logic                   s1_valid_q;
  logic [LANES-1:0][31:0] s1_t_q;
  logic [LANES-1:0][31:0] s1_sum_q;

  logic                   s2_valid_q;
  logic [LANES-1:0][31:0] s2_hi_q, s2_hi_d;
  logic [LANES-1:0][31:0] s2_corr_q, s2_corr_d;
  logic [LANES-1:0][31:0] s2_sum_q;
  logic [63:0]            prod [LANES];

  logic                   out_valid_q;
  logic [31:0]            pixel_d;
  logic [31:0]            pixel_q;
  logic [LANES-1:0][31:0] out_sum_q;
  logic [31:0]            avg;

  // Whole pipeline moves together; stalls only when the result is held.
  assign adv      = !out_valid_q || out_ready_i;
  assign op_pop_o = adv;
  assign take     = adv && op_valid_i;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      t_d[j] = sums_q[j] + {16'b0, stat_i.half};
      case (op_i.kind)
        KIND_LOAD: sums_d[j] = op_i.val[j];
        KIND_STEP: sums_d[j] = sums_q[j] + op_i.val[j];
        default:   sums_d[j] = sums_q[j];
      endcase
    end
  end

  // Signed t times unsigned recip: high word of the unsigned product,
  // minus recip when t is negative.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      prod[j]      = {32'b0, stat_i.recip} * {32'b0, s1_t_q[j]};
      s2_hi_d[j]   = prod[j][63:32];
      s2_corr_d[j] = s1_t_q[j][31] ? stat_i.recip : '0;
    end
  end

  // Lane averages overlap at byte offsets and carry upward.
  always_comb begin
    pixel_d = '0;
    avg     = '0;
    for (int j = 0; j < LANES; j++) begin
      avg     = s2_hi_q[j] - s2_corr_q[j];
      pixel_d = pixel_d + (avg << (8 * j));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (take) begin
        sums_q <= sums_d;
      end
      s1_valid_q  <= take && (op_i.kind == KIND_STEP);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_t_q    <= t_d;
      s1_sum_q  <= sums_d;
      s2_hi_q   <= s2_hi_d;
      s2_corr_q <= s2_corr_d;
      s2_sum_q  <= s1_sum_q;
      pixel_q   <= pixel_d;
      out_sum_q <= s2_sum_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.pixel_out = pixel_q;
  assign out_data_o.sum_out0  = out_sum_q[0];
  assign out_data_o.sum_out1  = out_sum_q[1];
  assign out_data_o.sum_out2  = out_sum_q[2];
  assign out_data_o.sum_out3  = out_sum_q[3];

endmodule

>>> hw/rtl/box_blur_running_average.sv
// A step item's result passes the queue, then the s1, s2 and output registers.
// Throughput: one item per cycle unless output stalls or recip is busy; a load
// item takes a slot but gives no result. A window write recomputes the
// reciprocal one quotient bit per cycle and holds off input while busy; results
// already in flight still drain. Reset clears lane sums, queue and pipeline
// valids; window returns to 3. Top level of the box blur running average block.
module box_blur_running_average #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bbra_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bbra_pkg::out_item_t out_data_o
);
  import bbra_pkg::*;

  recip_stat_t stat;
  op_t         push_op;
  op_t         pop_op;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;

  bbra_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat)
  );

  bbra_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .stat_i     (stat),
    .push_o     (push),
    .op_o       (push_op)
  );

  bbra_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_op)
  );

  bbra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (pop_op),
    .op_pop_o    (pop),
    .stat_i      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/bbra_checker.sv
// Port-level checks for the box blur block, bound to the top level.
`include "box_blur_running_average_macros.svh"

module bbra_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bbra_pkg::out_item_t out_data_o
);

  // A held result keeps its value until taken.
  `BBRA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Window write starts the reciprocal unit, which blocks input.
  `BBRA_ASSERT(a_cfg_stall, clk_i, rst_ni, cfg_we_i |=> !in_ready_o, "input taken during reciprocal update")

  // No result shows while reset is held.
  `BBRA_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind box_blur_running_average bbra_checker u_bbra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
